// ----- hdl/rgb_led_matrix_phase_renderer_defines.svh -----
// assertion macros used by the renderer top module
`ifndef RGB_LED_MATRIX_PHASE_RENDERER_DEFINES_SVH
`define RGB_LED_MATRIX_PHASE_RENDERER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising clock edge out of reset
`define RGBLM_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rgblm assertion failed");

// next-cycle implication
`define RGBLM_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rgblm assertion failed");

`else

`define RGBLM_ASSERT_IMP(name, pre, post)
`define RGBLM_ASSERT_NXT(name, pre, post)

`endif

`endif

// ----- hdl/rgblm_pkg.sv -----
package rgblm_pkg;

  localparam int unsigned ROWS_DEF       = 6;
  localparam int unsigned COLS_DEF       = 21;
  localparam int unsigned BRIGHT_MAX_DEF = 5;

  // color planes per pixel
  localparam int unsigned COMPONENTS = 3;

  localparam int unsigned BRIGHT_W = 3;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned DUTY_W   = 12;
  localparam int unsigned COLUMN_W = 5;
  localparam int unsigned SINK_W   = 5;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned PLANE_W  = 2;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd1;

  // function codes of an input transaction
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } rgblm_state_e;

  typedef struct packed {
    logic                func;
    logic [PLANE_W-1:0]  plane;
    logic [INDEX_W-1:0]  led_index;
    logic [VALUE_W-1:0]  value;
  } rgblm_in_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [DUTY_W-1:0]   duty;
    logic [SINK_W-1:0]   sink;
    logic                outputs_on;
    logic                last;
  } rgblm_out_t;

  // side information that travels with a framebuffer read
  typedef struct packed {
    logic                off;
    logic [COLUMN_W-1:0] column;
    logic [SINK_W-1:0]   sink;
    logic                last;
  } rgblm_tag_t;

endpackage

// ----- hdl/rgb_led_matrix_phase_renderer.sv -----
// channel       | signals                          | handshake
// --------------+----------------------------------+-------------------------------
// command in    | start, busy, in_i                | taken when start & !busy
// config write  | cfg_we_i, cfg_wdata_i            | brightness written when cfg_we_i
// result out    | res_valid_o, res_o               | one-cycle strobe, no backpressure
//
// a write transaction leaves busy low
// a render tick holds busy through the scan and drain states;
//   the column loop reads one framebuffer byte per cycle from the single read port
// after reset a clearing pass zeroes all 3*ROWS*COLS framebuffer bytes (378), busy high
// results pass the memory read register and then the duty register and cannot be stalled
`include "rgb_led_matrix_phase_renderer_defines.svh"

module rgb_led_matrix_phase_renderer
  import rgblm_pkg::*;
#(
  parameter int unsigned ROWS       = ROWS_DEF,
  parameter int unsigned COLS       = COLS_DEF,
  parameter int unsigned BRIGHT_MAX = BRIGHT_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rgblm_in_t           in_i,
  input  logic                cfg_we_i,
  input  logic [BRIGHT_W-1:0] cfg_wdata_i,
  output logic                res_valid_o,
  output rgblm_out_t          res_o
);

  localparam int unsigned PIXELS = ROWS * COLS;
  localparam int unsigned DEPTH  = COMPONENTS * PIXELS;
  localparam int unsigned PHASES = COMPONENTS * ROWS + 1;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PH_W   = $clog2(PHASES);

  rgblm_state_e state_q, state_d;

  // brightness register
  logic [BRIGHT_W-1:0] brightness_q;

  // phase bookkeeping: phase number plus the row and plane that it selects
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [PLANE_W-1:0] comp_q, comp_d;
  logic [ROW_W-1:0]   row_q, row_d;

  // clear counter and per-tick scan registers
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              off_q, off_d;
  logic [SINK_W-1:0] sink_q, sink_d;

  // read pipeline stage aligned with the memory output register
  logic       s1_valid_q;
  rgblm_tag_t s1_tag_q;

  logic               accept;
  logic               tick_accept;
  logic               wr_in_range;
  logic               issue;
  logic               col_last;
  rgblm_tag_t         tag;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [VALUE_W-1:0] mem_rdata;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign tick_accept = accept && (in_i.func == FUNC_TICK);
  assign col_last    = (col_q == COL_W'(COLS - 1));

  // out-of-range planes and indices are dropped
  assign wr_in_range = (32'(in_i.plane) < COMPONENTS) && (32'(in_i.led_index) < PIXELS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (off_q || col_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until the last read has moved into the duty stage
        if (!s1_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer: memory port control and the read tag
  always_comb begin
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = accept && (in_i.func == FUNC_WRITE) && wr_in_range;
        mem_waddr = AW'(32'(in_i.plane) * PIXELS + 32'(in_i.led_index));
        mem_wdata = in_i.value;
      end
      ST_SCAN: begin
        issue = 1'b1;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    // off phase needs no framebuffer byte
    mem_re = issue && !off_q;

    tag.off    = off_q;
    tag.column = off_q ? '0 : COLUMN_W'(col_q);
    tag.sink   = off_q ? '0 : sink_q;
    tag.last   = off_q || col_last;
  end

  // counters and phase advance
  always_comb begin
    clr_d   = clr_q;
    addr_d  = addr_q;
    col_d   = col_q;
    off_d   = off_q;
    sink_d  = sink_q;
    phase_d = phase_q;
    comp_d  = comp_q;
    row_d   = row_q;

    if (state_q == ST_CLEAR) begin
      clr_d = clr_q + AW'(1);
    end

    if (tick_accept) begin
      off_d  = (phase_q == '0);
      sink_d = SINK_W'(phase_q);
      col_d  = '0;
      // first byte of the selected row in the selected plane
      addr_d = AW'(32'(comp_q) * PIXELS + 32'(row_q) * COLS);
      if (phase_q == '0) begin
        phase_d = PH_W'(1);
        comp_d  = '0;
        row_d   = '0;
      end else if (phase_q == PH_W'(PHASES - 1)) begin
        phase_d = '0;
        comp_d  = '0;
        row_d   = '0;
      end else begin
        phase_d = phase_q + PH_W'(1);
        if (comp_q == PLANE_W'(COMPONENTS - 1)) begin
          comp_d = '0;
          row_d  = row_q + ROW_W'(1);
        end else begin
          comp_d = comp_q + PLANE_W'(1);
        end
      end
    end else if (issue) begin
      col_d  = col_q + COL_W'(1);
      addr_d = addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      brightness_q <= BRIGHT_RESET;
      phase_q      <= '0;
      comp_q       <= '0;
      row_q        <= '0;
      clr_q        <= '0;
      col_q        <= '0;
      off_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      comp_q     <= comp_d;
      row_q      <= row_d;
      clr_q      <= clr_d;
      col_q      <= col_d;
      off_q      <= off_d;
      s1_valid_q <= issue;
      if (cfg_we_i) begin
        brightness_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    sink_q   <= sink_d;
    s1_tag_q <= tag;
  end

  rgblm_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  rgblm_duty #(
    .BRIGHT_MAX (BRIGHT_MAX)
  ) u_duty (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid_q),
    .tag_i        (s1_tag_q),
    .pixel_i      (mem_rdata),
    .brightness_i (brightness_q),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  // writes and reads never share a cycle, so no forwarding is needed
  `RGBLM_ASSERT_IMP(a_no_rd_wr_overlap, mem_we, !mem_re)
  // results only come out while the block reports busy
  `RGBLM_ASSERT_IMP(a_res_while_busy, res_valid_o, busy)
  // a run of results has no gaps
  `RGBLM_ASSERT_NXT(a_run_contiguous, res_valid_o && !res_o.last, res_valid_o)
  // the final result of a run is followed by a quiet cycle
  `RGBLM_ASSERT_NXT(a_run_ends, res_valid_o && res_o.last, !res_valid_o)

endmodule

// ----- hdl/rgblm_frame_mem.sv -----
module rgblm_frame_mem
  import rgblm_pkg::*;
#(
  parameter int unsigned DEPTH = COMPONENTS * ROWS_DEF * COLS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rgblm_duty.sv -----
module rgblm_duty
  import rgblm_pkg::*;
#(
  parameter int unsigned BRIGHT_MAX = BRIGHT_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rgblm_tag_t          tag_i,
  input  logic [VALUE_W-1:0]  pixel_i,
  input  logic [BRIGHT_W-1:0] brightness_i,
  output logic                res_valid_o,
  output rgblm_out_t          res_o
);

  localparam int unsigned PROD_W   = VALUE_W + BRIGHT_W + 1;
  localparam int unsigned DUTY_SAT = (1 << DUTY_W) - 1;

  logic [BRIGHT_W-1:0] bright_eff;
  logic [PROD_W-1:0]   prod;
  logic [DUTY_W-1:0]   duty;
  logic                res_valid_q;
  rgblm_out_t          res_d, res_q;

  // clamp to the top level, then pixel * level * 2, saturated at the duty maximum
  always_comb begin
    if ({1'b0, brightness_i} > 4'(BRIGHT_MAX)) begin
      bright_eff = BRIGHT_W'(BRIGHT_MAX);
    end else begin
      bright_eff = brightness_i;
    end
    prod = {PROD_W'(pixel_i) * PROD_W'(bright_eff)} << 1;
    if (prod > PROD_W'(DUTY_SAT)) begin
      duty = DUTY_W'(DUTY_SAT);
    end else begin
      duty = DUTY_W'(prod);
    end
  end

  always_comb begin
    res_d.column     = tag_i.column;
    res_d.duty       = tag_i.off ? '0 : duty;
    res_d.sink       = tag_i.sink;
    res_d.outputs_on = !tag_i.off;
    res_d.last       = tag_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
